>>> design/acds_pkg.sv
// Shared types, constants and state codes for the accelerometer calibration block.
package acds_pkg;

  // ADC and conversion constants
  localparam int ADC_BITS = 10;
  localparam int RAW_W    = 10;
  localparam int ADC_MAX  = (1 << ADC_BITS) - 1;
  localparam int G_BIAS   = 10240;
  localparam int ONE_G    = 4096;
  localparam int ONE_Q15  = 32768;
  localparam int HALF_Q15 = 16384;

  // Converted sample width, signed Q4.12 within +-10240
  localparam int G_W = 15;

  // Serial divider: one quotient bit a cycle
  localparam int DIV_Q_W = 16;
  localparam int DIV_D_W = 15;
  localparam int DIV_N_W = DIV_Q_W + DIV_D_W;
  localparam logic [DIV_D_W-1:0] CONV_DEN = DIV_D_W'(2 * ADC_MAX);

  // Serial multiplier operand width
  localparam int MUL_W = 16;

  // Register indexes
  localparam logic [2:0] REG_MAX_G     = 3'd0;
  localparam logic [2:0] REG_DEADZONE  = 3'd1;
  localparam logic [2:0] REG_SMOOTHING = 3'd2;
  localparam logic [2:0] REG_CAL_COUNT = 3'd3;
  localparam logic [2:0] REG_AXIS      = 3'd4;

  // Axis codes
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;

  typedef struct packed {
    logic             kind;
    logic [RAW_W-1:0] raw_x;
    logic [RAW_W-1:0] raw_y;
    logic [RAW_W-1:0] raw_z;
  } sample_t;

  typedef struct packed {
    logic signed [15:0] g_x;
    logic signed [15:0] g_y;
    logic signed [15:0] g_z;
    logic signed [15:0] movement;
    logic               cal_done;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CONV_GO,
    ST_CONV_WAIT,
    ST_APPLY,
    ST_MEAN_GO,
    ST_MEAN_WAIT,
    ST_MEAN_FIN,
    ST_NORM_GO,
    ST_NORM_WAIT,
    ST_MUL_GO,
    ST_MUL_WAIT,
    ST_FILT,
    ST_DONE
  } state_t;

endpackage

>>> design/acds_div.sv
// Restoring divider that retires one quotient bit per cycle.
module acds_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [acds_pkg::DIV_N_W-1:0]   num,
  input  logic [acds_pkg::DIV_D_W-1:0]   den,
  output logic                           busy,
  output logic [acds_pkg::DIV_Q_W-1:0]   quo
);
  import acds_pkg::*;

  localparam int CNT_W = $clog2(DIV_Q_W);

  logic [DIV_D_W-1:0] rem;
  logic [DIV_D_W-1:0] divisor;
  logic [DIV_Q_W-1:0] shreg;
  logic [CNT_W-1:0]   step;
  logic [DIV_D_W:0]   trial;
  logic [DIV_D_W:0]   diff;
  logic               fits;

  // Bring down the next dividend bit and try a subtract
  assign trial = {rem, shreg[DIV_Q_W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign fits  = trial >= {1'b0, divisor};

  // Step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= '0;
    end else if (busy) begin
      step <= step + CNT_W'(1);
      if (step == CNT_W'(DIV_Q_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Remainder and dividend/quotient shift register; high part of num is below den
  always_ff @(posedge clk) begin
    if (start) begin
      rem     <= num[DIV_N_W-1:DIV_Q_W];
      shreg   <= num[DIV_Q_W-1:0];
      divisor <= den;
    end else if (busy) begin
      rem   <= fits ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
      shreg <= {shreg[DIV_Q_W-2:0], fits};
    end
  end

  assign quo = shreg;

endmodule

>>> design/acds_mul.sv
// Shift-add multiplier that consumes one multiplier bit per cycle.
module acds_mul (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [acds_pkg::MUL_W-1:0]     a,
  input  logic [acds_pkg::MUL_W-1:0]     b,
  output logic                           busy,
  output logic [2*acds_pkg::MUL_W-1:0]   prod
);
  import acds_pkg::*;

  localparam int CNT_W = $clog2(MUL_W);

  logic [MUL_W-1:0] mcand;
  logic [MUL_W-1:0] hi;
  logic [MUL_W-1:0] lo;
  logic [MUL_W:0]   sum;
  logic [CNT_W-1:0] step;

  // Add the multiplicand when the current multiplier bit is set
  assign sum = {1'b0, hi} + (lo[0] ? {1'b0, mcand} : '0);

  // Step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= '0;
    end else if (busy) begin
      step <= step + CNT_W'(1);
      if (step == CNT_W'(MUL_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Shift the partial product right one bit per step
  always_ff @(posedge clk) begin
    if (start) begin
      hi    <= '0;
      lo    <= b;
      mcand <= a;
    end else if (busy) begin
      {hi, lo} <= {sum, lo[MUL_W-1:1]};
    end
  end

  assign prod = {hi, lo};

endmodule

>>> design/accel_calibrate_deadzone_smooth.sv
// Top level: ADC conversion, offset calibration, deadzone, normalization and smoothing.
// Every accepted sample is converted; a calibration beat that does not complete or a measure
// beat inside the deadzone then goes to the result, a completing calibration beat first runs a
// mean division and a filtered measure beat a normalization division and a multiply, on 16-step
// bit-serial dividers and a 16-step multiplier. The next sample is taken once the result is loaded.
// Synchronous active-high reset restores register defaults and clears offsets, sums,
// calibration count and filter state at once.
module accel_calibrate_deadzone_smooth #(
  parameter int MAX_CAL_SAMPLES = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              sample_valid,
  output logic              sample_ready,
  input  acds_pkg::sample_t sample,
  output logic              result_valid,
  input  logic              result_ready,
  output acds_pkg::result_t result,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_idx,
  input  logic [15:0]       cfg_data
);
  import acds_pkg::*;

  localparam int LIM_MAX = (MAX_CAL_SAMPLES < 2047) ? MAX_CAL_SAMPLES : 2047;
  localparam int CNT_W   = $clog2(LIM_MAX + 1);
  localparam int SUM_W   = G_W + CNT_W;

  // Configuration registers
  logic [14:0] max_g;
  logic [14:0] deadzone;
  logic [15:0] smoothing;
  logic [10:0] cal_count;
  logic [1:0]  movement_axis;

  // Block state
  state_t                    state, state_next;
  logic signed [15:0]        offset [3];
  logic signed [SUM_W-1:0]   sum [3];
  logic [CNT_W-1:0]          cal_counter;
  logic signed [15:0]        filter_value;

  // Working registers
  sample_t                   smp;
  logic signed [15:0]        res_g [3];
  logic signed [15:0]        res_mov;
  logic                      res_done;
  logic                      norm_neg;
  logic [14:0]               norm_mag;
  logic                      d_neg;

  // Lane signals
  logic [DIV_N_W-1:0]        lane_num [3];
  logic [DIV_D_W-1:0]        lane_den [3];
  logic                      lane_start [3];
  logic                      lane_busy [3];
  logic [DIV_Q_W-1:0]        lane_quo [3];
  logic [RAW_W-1:0]          raw [3];
  logic signed [15:0]        conv_g [3];

  // Multiplier signals
  logic                      mul_start;
  logic                      mul_busy;
  logic [MUL_W-1:0]          mul_a;
  logic [2*MUL_W-1:0]        mul_prod;

  // Control outputs
  logic                      conv_go;
  logic                      mean_go;
  logic                      norm_go;
  logic                      load_result;

  // Derived values
  logic [CNT_W-1:0]          cal_lim;
  logic [CNT_W-1:0]          cnt_inc;
  logic                      cal_complete;
  logic [14:0]               max_lim;
  logic [15:0]               s_eff;
  logic signed [15:0]        corr [3];
  logic signed [16:0]        sel_v;
  logic signed [16:0]        dz_s;
  logic signed [16:0]        lim_s;
  logic signed [16:0]        clamp_v;
  logic                      in_dz;
  logic signed [16:0]        mv;
  logic signed [16:0]        d_val;
  logic signed [32:0]        total;
  logic [32:0]               total_mag;
  logic [32:0]               round_sum;
  logic [15:0]               f_mag;
  logic signed [15:0]        f_new;

  function automatic logic [DIV_N_W-1:0] conv_num(input logic [RAW_W-1:0] r_in);
    logic [DIV_N_W-1:0] r;
    r = DIV_N_W'(r_in[ADC_BITS-1:0]);
    // raw * 40960 + ADC_MAX
    return (r << 15) + (r << 13) + DIV_N_W'(ADC_MAX);
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
    logic signed [15:0] o;
    if (v > 17'sd32767) begin
      o = 16'sh7FFF;
    end else if (v < -17'sd32768) begin
      o = 16'sh8000;
    end else begin
      o = v[15:0];
    end
    return o;
  endfunction

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      max_g         <= 15'd3277;
      deadzone      <= 15'd410;
      smoothing     <= 16'd6554;
      cal_count     <= 11'd64;
      movement_axis <= 2'd0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_MAX_G:     max_g         <= cfg_data[14:0];
        REG_DEADZONE:  deadzone      <= cfg_data[14:0];
        REG_SMOOTHING: smoothing     <= cfg_data;
        REG_CAL_COUNT: cal_count     <= cfg_data[10:0];
        REG_AXIS:      movement_axis <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Effective limits
  always_comb begin
    if (cal_count == '0) begin
      cal_lim = CNT_W'(1);
    end else if (32'(cal_count) > 32'(LIM_MAX)) begin
      cal_lim = CNT_W'(LIM_MAX);
    end else begin
      cal_lim = CNT_W'(cal_count);
    end
  end

  assign max_lim = (max_g == '0) ? 15'd1 : max_g;
  assign s_eff   = (smoothing > 16'(ONE_Q15)) ? 16'(ONE_Q15) : smoothing;

  assign raw[0] = smp.raw_x;
  assign raw[1] = smp.raw_y;
  assign raw[2] = smp.raw_z;

  // Divider lanes, one per axis; lane 0 also normalizes
  for (genvar i = 0; i < 3; i++) begin : g_lane
    always_comb begin
      if (mean_go) begin
        lane_num[i] = DIV_N_W'(sum[i][SUM_W-1] ? -sum[i] : sum[i])
                      + DIV_N_W'(cal_lim >> 1);
        lane_den[i] = DIV_D_W'(cal_lim);
      end else if (norm_go && i == 0) begin
        lane_num[i] = (DIV_N_W'(norm_mag) << 14) + DIV_N_W'(max_lim >> 1);
        lane_den[i] = max_lim;
      end else begin
        lane_num[i] = conv_num(raw[i]);
        lane_den[i] = CONV_DEN;
      end
    end

    assign lane_start[i] = conv_go || mean_go || (norm_go && i == 0);
    assign conv_g[i]     = signed'(lane_quo[i] - 16'(G_BIAS));
    assign corr[i]       = sat16(17'(conv_g[i]) - 17'(offset[i]));

    acds_div u_div (
      .clk   (clk),
      .rst   (rst),
      .start (lane_start[i]),
      .num   (lane_num[i]),
      .den   (lane_den[i]),
      .busy  (lane_busy[i]),
      .quo   (lane_quo[i])
    );
  end

  // Calibration progress
  assign cnt_inc      = cal_counter + CNT_W'(1);
  assign cal_complete = cnt_inc >= cal_lim;

  // Axis select, deadzone test and clamp
  always_comb begin
    unique case (movement_axis)
      AXIS_X:  sel_v = 17'(corr[0]);
      AXIS_Y:  sel_v = 17'(corr[1]);
      default: sel_v = 17'(corr[2]);
    endcase
    dz_s  = signed'({2'b00, deadzone});
    lim_s = signed'({2'b00, max_lim});
    in_dz = (sel_v > -dz_s) && (sel_v < dz_s);
    if (sel_v > lim_s) begin
      clamp_v = lim_s;
    end else if (sel_v < -lim_s) begin
      clamp_v = -lim_s;
    end else begin
      clamp_v = sel_v;
    end
  end

  // Normalized value and filter step
  assign mv    = norm_neg ? -signed'({1'b0, lane_quo[0]}) : signed'({1'b0, lane_quo[0]});
  assign d_val = mv - 17'(filter_value);
  assign mul_a = MUL_W'(d_val[16] ? -d_val : d_val);

  always_comb begin
    total     = (33'(filter_value) <<< 15)
                + (d_neg ? -signed'({1'b0, mul_prod}) : signed'({1'b0, mul_prod}));
    total_mag = total[32] ? 33'(-total) : 33'(total);
    round_sum = total_mag + 33'(HALF_Q15);
    f_mag     = round_sum[30:15];
    f_new     = total[32] ? -signed'(f_mag) : signed'(f_mag);
  end

  acds_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (s_eff),
    .busy  (mul_busy),
    .prod  (mul_prod)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:      if (sample_valid) state_next = ST_CONV_GO;
      ST_CONV_GO:   state_next = ST_CONV_WAIT;
      ST_CONV_WAIT: if (!lane_busy[0]) state_next = ST_APPLY;
      ST_APPLY: begin
        if (smp.kind) begin
          state_next = cal_complete ? ST_MEAN_GO : ST_DONE;
        end else begin
          state_next = in_dz ? ST_DONE : ST_NORM_GO;
        end
      end
      ST_MEAN_GO:   state_next = ST_MEAN_WAIT;
      ST_MEAN_WAIT: if (!lane_busy[0]) state_next = ST_MEAN_FIN;
      ST_MEAN_FIN:  state_next = ST_DONE;
      ST_NORM_GO:   state_next = ST_NORM_WAIT;
      ST_NORM_WAIT: if (!lane_busy[0]) state_next = ST_MUL_GO;
      ST_MUL_GO:    state_next = ST_MUL_WAIT;
      ST_MUL_WAIT:  if (!mul_busy) state_next = ST_FILT;
      ST_FILT:      state_next = ST_DONE;
      ST_DONE:      if (!result_valid || result_ready) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // Control outputs; take no beat while in reset
  always_comb begin
    sample_ready = (state == ST_IDLE) && !rst;
    conv_go      = (state == ST_CONV_GO);
    mean_go      = (state == ST_MEAN_GO);
    norm_go      = (state == ST_NORM_GO);
    mul_start    = (state == ST_MUL_GO);
    load_result  = (state == ST_DONE) && (!result_valid || result_ready);
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Capture the accepted sample beat
  always_ff @(posedge clk) begin
    if (sample_valid && sample_ready) begin
      smp <= sample;
    end
  end

  // Calibration state, offsets and filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        offset[i] <= '0;
        sum[i]    <= '0;
      end
      cal_counter  <= '0;
      filter_value <= '0;
    end else begin
      if (state == ST_APPLY && smp.kind) begin
        for (int i = 0; i < 3; i++) begin
          sum[i] <= sum[i] + SUM_W'(conv_g[i]);
        end
        cal_counter <= cal_complete ? '0 : cnt_inc;
      end
      if (state == ST_MEAN_FIN) begin
        for (int i = 0; i < 3; i++) begin
          sum[i] <= '0;
        end
        for (int i = 0; i < 2; i++) begin
          offset[i] <= sum[i][SUM_W-1] ? -signed'(lane_quo[i]) : signed'(lane_quo[i]);
        end
        // Take 1 g off the z mean
        offset[2] <= (sum[2][SUM_W-1] ? -signed'(lane_quo[2]) : signed'(lane_quo[2]))
                     - 16'sd4096;
      end
      if (state == ST_FILT) begin
        filter_value <= f_new;
      end
    end
  end

  // Working result fields
  always_ff @(posedge clk) begin
    if (state == ST_APPLY) begin
      res_done <= 1'b0;
      res_mov  <= '0;
      norm_neg <= clamp_v[16];
      norm_mag <= 15'(clamp_v[16] ? -clamp_v : clamp_v);
      for (int i = 0; i < 3; i++) begin
        res_g[i] <= smp.kind ? 16'sd0 : corr[i];
      end
    end
    if (state == ST_MEAN_FIN) begin
      res_done <= 1'b1;
    end
    if (state == ST_MUL_GO) begin
      d_neg <= d_val[16];
    end
    if (state == ST_FILT) begin
      res_mov <= f_new;
    end
  end

  // Output register: hold the beat until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_result) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      result.g_x      <= res_g[0];
      result.g_y      <= res_g[1];
      result.g_z      <= res_g[2];
      result.movement <= res_mov;
      result.cal_done <= res_done;
    end
  end

endmodule

>>> test/accel_calibrate_deadzone_smooth_tb.sv
// Testbench for the accelerometer calibration, deadzone and smoothing block.
`timescale 1ns / 1ps

module accel_calibrate_deadzone_smooth_tb;
  import acds_pkg::*;

  localparam int CAL_CAP      = 1024;
  localparam int ONE_Q14      = 16384;
  localparam int SCALE_X2     = 40960;
  localparam int REST_XY      = 512;
  localparam int REST_Z       = 716;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam logic KIND_MEASURE = 1'b0;
  localparam logic KIND_CAL     = 1'b1;
  localparam logic [1:0] AXIS_Z      = 2'd2;
  localparam logic [1:0] AXIS_UNUSED = 2'd3;

  // Predict readings and hold them until the block delivers them
  class accel_tracker;
    result_t owed_readings[$];
    int      errors;
    int      max_g, deadzone, smoothing, cal_count, axis;
    int      off_x, off_y, off_z, cal_seen, filt;
    longint  sum_x, sum_y, sum_z;

    function new();
      max_g     = 3277;
      deadzone  = 410;
      smoothing = 6554;
      cal_count = 64;
      axis      = AXIS_X;
      off_x = 0; off_y = 0; off_z = 0; cal_seen = 0; filt = 0;
      sum_x = 0; sum_y = 0; sum_z = 0;
      errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [15:0] data);
      case (idx)
        REG_MAX_G:     max_g     = int'(data[14:0]);
        REG_DEADZONE:  deadzone  = int'(data[14:0]);
        REG_SMOOTHING: smoothing = int'(data);
        REG_CAL_COUNT: cal_count = int'(data[10:0]);
        REG_AXIS:      axis      = int'(data[1:0]);
        default: ;
      endcase
    endfunction

    function int cal_limit();
      if (cal_count == 0) return 1;
      if (cal_count > CAL_CAP) return CAL_CAP;
      return cal_count;
    endfunction

    // ADC count to Q4.12 g, rounded half up
    function int to_q12(logic [RAW_W-1:0] raw);
      int r;
      r = int'(raw);
      return (r * SCALE_X2 + ADC_MAX) / (2 * ADC_MAX) - G_BIAS;
    endfunction

    // Divide, rounding half away from zero
    function longint round_div(longint num, longint den);
      longint mag, q;
      mag = (num < 0) ? -num : num;
      q   = (mag + den / 2) / den;
      return (num < 0) ? -q : q;
    endfunction

    function int clamp16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return int'(v);
    endfunction

    function void note_sample(sample_t s);
      result_t r;
      int gx, gy, gz, ox, oy, oz, v, lim, mv, w, limit;
      gx = to_q12(s.raw_x);
      gy = to_q12(s.raw_y);
      gz = to_q12(s.raw_z);
      r  = '0;
      if (s.kind == KIND_CAL) begin
        // Accumulate; on the last sample of the set, update the offsets
        limit = cal_limit();
        sum_x += gx;
        sum_y += gy;
        sum_z += gz;
        cal_seen++;
        if (cal_seen >= limit) begin
          off_x = clamp16(round_div(sum_x, limit));
          off_y = clamp16(round_div(sum_y, limit));
          off_z = clamp16(round_div(sum_z, limit) - ONE_G);
          sum_x = 0; sum_y = 0; sum_z = 0;
          cal_seen = 0;
          r.cal_done = 1'b1;
        end
      end else begin
        ox = clamp16(gx - off_x);
        oy = clamp16(gy - off_y);
        oz = clamp16(gz - off_z);
        r.g_x = 16'(ox);
        r.g_y = 16'(oy);
        r.g_z = 16'(oz);
        v = (axis == AXIS_X) ? ox : (axis == AXIS_Y) ? oy : oz;
        // Outside the deadzone: clamp, normalize and run the filter
        if (!(v > -deadzone && v < deadzone)) begin
          lim = (max_g == 0) ? 1 : max_g;
          if (v > lim) v = lim;
          if (v < -lim) v = -lim;
          mv = int'(round_div(longint'(v) * ONE_Q14, lim));
          w  = (smoothing > ONE_Q15) ? ONE_Q15 : smoothing;
          filt = int'(round_div(longint'(filt) * (ONE_Q15 - w) + longint'(mv) * w, ONE_Q15));
          r.movement = 16'(filt);
        end
      end
      owed_readings.push_back(r);
    endfunction

    function void field_check(string name, logic signed [16:0] want, logic signed [16:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (owed_readings.size() == 0) begin
        $display("%0t: result with nothing pending: expected none, got %h", $time, got);
        errors++;
        return;
      end
      want = owed_readings.pop_front();
      field_check("g_x", want.g_x, got.g_x);
      field_check("g_y", want.g_y, got.g_y);
      field_check("g_z", want.g_z, got.g_z);
      field_check("movement", want.movement, got.movement);
      field_check("cal_done", want.cal_done, got.cal_done);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        sample_valid;
  logic        sample_ready;
  sample_t     sample_bus;
  logic        result_valid;
  logic        result_ready;
  result_t     result_bus;
  logic        cfg_we;
  logic [2:0]  cfg_idx;
  logic [15:0] cfg_data;

  accel_tracker tracker = new();
  bit  idle_on     = 1'b1;
  int  hold_cycles = 0;
  int  cycle_count = 0;

  accel_calibrate_deadzone_smooth #(.MAX_CAL_SAMPLES(CAL_CAP)) u_top (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample_bus),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result_bus),
    .cfg_we       (cfg_we),
    .cfg_idx      (cfg_idx),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Note accepted beats on both channels
  always @(posedge clk) begin
    if (!rst) begin
      if (sample_valid && sample_ready) tracker.note_sample(sample_bus);
      if (result_valid && result_ready) tracker.check_result(result_bus);
    end
  end

  // Stop a hung run
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // Result side: random stalls, plus one long hold-off on request
  initial begin
    int stall;
    result_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        stall = hold_cycles;
        hold_cycles = 0;
        result_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end else begin
        stall = idle_on ? $urandom_range(0, 10) : 0;
        if (stall > 0) begin
          result_ready <= 1'b0;
          do @(posedge clk); while (!result_valid);
          repeat (stall - 1) @(posedge clk);
        end
      end
      result_ready <= 1'b1;
      do @(posedge clk); while (!(result_valid && result_ready));
    end
  end

  function automatic logic [RAW_W-1:0] near(int center, int spread);
    int v;
    v = center + int'($urandom_range(0, 2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > ADC_MAX) v = ADC_MAX;
    return v[RAW_W-1:0];
  endfunction

  // Sample around the resting pose: level, 1 g on z
  function automatic sample_t rest_sample(logic kind, int spread);
    sample_t s;
    s.kind  = kind;
    s.raw_x = near(REST_XY, spread);
    s.raw_y = near(REST_XY, spread);
    s.raw_z = near(REST_Z, spread);
    return s;
  endfunction

  // Offer one beat after a random gap; hold valid until accepted
  task automatic send_sample(input sample_t s);
    int gap;
    gap = idle_on ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample_bus   <= s;
    do @(posedge clk); while (!sample_ready);
  endtask

  task automatic send_raw(input logic kind, input int x, input int y, input int z);
    sample_t s;
    s.kind  = kind;
    s.raw_x = RAW_W'(x);
    s.raw_y = RAW_W'(y);
    s.raw_z = RAW_W'(z);
    send_sample(s);
  endtask

  // Drop valid and wait until every reading is back
  task automatic drain();
    sample_valid <= 1'b0;
    do @(posedge clk); while (tracker.owed_readings.size() != 0);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    tracker.set_reg(idx, data);
    @(posedge clk);
  endtask

  task automatic apply_setting(input int mg, input int dz, input int sm, input int cc,
                               input logic [1:0] ax);
    write_reg(REG_MAX_G, 16'(mg));
    write_reg(REG_DEADZONE, 16'(dz));
    write_reg(REG_SMOOTHING, 16'(sm));
    write_reg(REG_CAL_COUNT, 16'(cc));
    write_reg(REG_AXIS, 16'(ax));
    cfg_we <= 1'b0;
  endtask

  task automatic random_setting(input int cc);
    int mg, dz, sm;
    case ($urandom_range(0, 4))
      0:       mg = 0;
      1:       mg = 1;
      2:       mg = 32767;
      3:       mg = $urandom_range(1, 32767);
      default: mg = $urandom_range(800, 8000);
    endcase
    case ($urandom_range(0, 4))
      0:       dz = 0;
      1:       dz = 32767;
      2:       dz = $urandom_range(0, 32767);
      default: dz = $urandom_range(0, 1500);
    endcase
    case ($urandom_range(0, 4))
      0:       sm = 0;
      1:       sm = ONE_Q15;
      2:       sm = 65535;
      3:       sm = $urandom_range(0, 65535);
      default: sm = $urandom_range(1000, ONE_Q15);
    endcase
    apply_setting(mg, dz, sm, cc, 2'($urandom_range(0, 3)));
  endtask

  // Calibration sets, measurements near rest, and some noise
  task automatic run_mixed(input int n_items);
    int sent, pick, spread, burst;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (sent == 0 || pick < 12) begin
        burst = tracker.cal_limit();
        repeat (burst) send_sample(rest_sample(KIND_CAL, 4));
        sent += burst;
      end else if (pick < 22) begin
        send_sample(rest_sample(1'($urandom_range(0, 1)), ADC_MAX));
        sent++;
      end else begin
        case ($urandom_range(0, 3))
          0:       spread = 0;
          1:       spread = 20;
          2:       spread = 80;
          default: spread = 512;
        endcase
        send_sample(rest_sample(KIND_MEASURE, spread));
        sent++;
      end
    end
  endtask

  initial begin
    int phase;
    rst          <= 1'b1;
    sample_valid <= 1'b0;
    sample_bus   <= '0;
    cfg_we       <= 1'b0;
    cfg_idx      <= '0;
    cfg_data     <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: raw extremes, mid scale, edge of the deadzone
    send_raw(KIND_MEASURE, 0, 0, 0);
    send_raw(KIND_MEASURE, 1023, 1023, 1023);
    send_raw(KIND_MEASURE, 512, 512, 512);
    send_raw(KIND_MEASURE, 531, 0, 1023);
    send_raw(KIND_CAL, 1023, 0, 512);
    drain();

    // Zero limits, zero deadzone, oversized weight, unused axis code
    apply_setting(0, 0, 65535, 0, AXIS_UNUSED);
    send_raw(KIND_CAL, 1023, 1023, 1023);
    send_raw(KIND_MEASURE, 0, 0, 0);
    send_raw(KIND_MEASURE, 1023, 1023, 1023);
    send_raw(KIND_MEASURE, 512, 512, 512);
    drain();

    // Widest deadzone, no smoothing, count above the cap
    apply_setting(32767, 32767, 0, 2047, AXIS_Y);
    send_raw(KIND_CAL, 0, 0, 0);
    send_raw(KIND_CAL, 1023, 1023, 1023);
    send_raw(KIND_MEASURE, 0, 1023, 0);
    send_raw(KIND_MEASURE, 1023, 0, 1023);
    drain();

    // Smallest limits, full weight, z axis
    apply_setting(1, 1, ONE_Q15, 1, AXIS_Z);
    send_raw(KIND_CAL, 512, 512, 716);
    send_raw(KIND_MEASURE, 512, 512, 716);
    send_raw(KIND_MEASURE, 513, 512, 740);
    send_raw(KIND_MEASURE, 0, 0, 0);
    drain();

    // Short calibration set, then tilt both ways on x
    apply_setting(4096, 100, 16384, 3, AXIS_X);
    send_raw(KIND_CAL, 500, 520, 716);
    send_raw(KIND_CAL, 510, 515, 720);
    send_raw(KIND_CAL, 530, 505, 712);
    send_raw(KIND_MEASURE, 600, 512, 716);
    send_raw(KIND_MEASURE, 400, 512, 716);
    send_raw(KIND_MEASURE, 512, 512, 716);
    drain();

    // Random phases; one runs a full-size calibration set
    for (phase = 0; phase < 7; phase++) begin
      idle_on = ($urandom_range(0, 3) != 0);
      if (phase == 3) begin
        random_setting(2047);
        repeat (1030) send_sample(rest_sample(KIND_CAL, 6));
        repeat (20) send_sample(rest_sample(KIND_MEASURE, 40));
      end else begin
        random_setting($urandom_range(0, 12));
        // Hold results back long enough to back up the input
        if (phase == 1) hold_cycles = 400;
        run_mixed(60);
        // Let the block run dry mid-phase
        if (phase == 2) drain();
        run_mixed(60);
      end
      drain();
    end

    repeat (80) @(posedge clk);
    if (tracker.errors == 0 && tracker.owed_readings.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
